/* src/retarder_override_controller_macros.svh */
// assertion helpers for the controller modules, used by the result sequencer
// each macro expects clk_i and rst_ni in the enclosing scope
`ifndef RETARDER_OVERRIDE_CONTROLLER_MACROS_SVH
`define RETARDER_OVERRIDE_CONTROLLER_MACROS_SVH

// same-cycle implication
`define ROC_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ROC_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/roc_pkg.sv */
`default_nettype none

package roc_pkg;

  // input commands
  typedef enum logic [1:0] {
    CMD_OVERRIDE = 2'd0,
    CMD_TICK     = 2'd1,
    CMD_REQUEST  = 2'd2
  } cmd_e;

  // override modes, low two bits of the control byte
  localparam logic [1:0] MODE_STOP = 2'd0;

  // register map, index = paddr[4:2]
  typedef enum logic [2:0] {
    REG_TORQUE_MODE     = 3'd0,
    REG_ASSIST_ENABLES  = 3'd1,
    REG_ACTUAL_TORQUE   = 3'd2,
    REG_INTENDED_TORQUE = 3'd3,
    REG_LOAD_LIGHT      = 3'd4,
    REG_DRIVER_DEMAND   = 3'd5,
    REG_RETARDER_SEL    = 3'd6,
    REG_MAX_AVAIL       = 3'd7
  } reg_idx_e;

  localparam int unsigned PADDR_W = 5;

  localparam logic [23:0] STATUS_PGN = 24'd61440;
  localparam logic [7:0]  NO_ADDRESS = 8'hFF;
  localparam logic [3:0]  BYTE3_HIGH = 4'hF;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_FRAME  = 1'b1;

  // frame byte positions
  localparam logic [2:0] LAST_FRAME_BYTE = 3'd7;

  // configuration register reset values
  localparam logic [3:0] RST_TORQUE_MODE     = 4'd15;
  localparam logic [3:0] RST_ASSIST_ENABLES  = 4'd5;
  localparam logic [7:0] RST_ACTUAL_TORQUE   = 8'd125;
  localparam logic [7:0] RST_INTENDED_TORQUE = 8'd125;
  localparam logic [3:0] RST_LOAD_LIGHT      = 4'd15;
  localparam logic [7:0] RST_DRIVER_DEMAND   = 8'd75;
  localparam logic [7:0] RST_RETARDER_SEL    = 8'd255;
  localparam logic [7:0] RST_MAX_AVAIL       = 8'd0;

  typedef struct packed {
    logic [3:0] torque_mode;
    logic [3:0] assist_enables;
    logic [7:0] actual_torque;
    logic [7:0] intended_torque;
    logic [3:0] load_and_light_bits;
    logic [7:0] driver_demand_torque;
    logic [7:0] retarder_selection;
    logic [7:0] max_available_torque;
  } cfg_t;

  // one accepted item, as handed from the core to the result sequencer
  typedef struct packed {
    logic       send;
    logic       snd_active;
    logic [7:0] snd_addr;
    logic       changed;
    logic       active;
    logic [7:0] addr;
  } job_t;

endpackage

`default_nettype wire

/* src/roc_in_if.sv */
`default_nettype none

interface roc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] now_ms;
  logic [7:0]  source_address;
  logic [7:0]  control_byte;
  logic [23:0] requested_pgn;

  modport source (
    output valid, command, now_ms, source_address, control_byte, requested_pgn,
    input  ready
  );
  modport sink (
    input  valid, command, now_ms, source_address, control_byte, requested_pgn,
    output ready
  );
endinterface

`default_nettype wire

/* src/roc_out_if.sv */
`default_nettype none

interface roc_out_if;
  logic       valid;
  logic       ready;
  logic       kind;
  logic       changed;
  logic       active;
  logic [7:0] controller_address;
  logic [7:0] frame_byte;
  logic [2:0] byte_index;
  logic       last;

  modport source (
    output valid, kind, changed, active, controller_address, frame_byte, byte_index, last,
    input  ready
  );
  modport sink (
    input  valid, kind, changed, active, controller_address, frame_byte, byte_index, last,
    output ready
  );
endinterface

`default_nettype wire

/* src/roc_regs.sv */
`default_nettype none

module roc_regs (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [roc_pkg::PADDR_W-1:0]   paddr,
  input  wire logic [31:0]                   pwdata,
  output      logic [31:0]                   prdata,
  output      logic                          pready,
  output      roc_pkg::cfg_t                 cfg_o
);

  roc_pkg::cfg_t    cfg_q;
  roc_pkg::reg_idx_e idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign idx    = roc_pkg::reg_idx_e'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign cfg_o  = cfg_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.torque_mode          <= roc_pkg::RST_TORQUE_MODE;
      cfg_q.assist_enables       <= roc_pkg::RST_ASSIST_ENABLES;
      cfg_q.actual_torque        <= roc_pkg::RST_ACTUAL_TORQUE;
      cfg_q.intended_torque      <= roc_pkg::RST_INTENDED_TORQUE;
      cfg_q.load_and_light_bits  <= roc_pkg::RST_LOAD_LIGHT;
      cfg_q.driver_demand_torque <= roc_pkg::RST_DRIVER_DEMAND;
      cfg_q.retarder_selection   <= roc_pkg::RST_RETARDER_SEL;
      cfg_q.max_available_torque <= roc_pkg::RST_MAX_AVAIL;
    end else if (wr_en) begin
      case (idx)
        roc_pkg::REG_TORQUE_MODE:     cfg_q.torque_mode          <= pwdata[3:0];
        roc_pkg::REG_ASSIST_ENABLES:  cfg_q.assist_enables       <= pwdata[3:0];
        roc_pkg::REG_ACTUAL_TORQUE:   cfg_q.actual_torque        <= pwdata[7:0];
        roc_pkg::REG_INTENDED_TORQUE: cfg_q.intended_torque      <= pwdata[7:0];
        roc_pkg::REG_LOAD_LIGHT:      cfg_q.load_and_light_bits  <= pwdata[3:0];
        roc_pkg::REG_DRIVER_DEMAND:   cfg_q.driver_demand_torque <= pwdata[7:0];
        roc_pkg::REG_RETARDER_SEL:    cfg_q.retarder_selection   <= pwdata[7:0];
        roc_pkg::REG_MAX_AVAIL:       cfg_q.max_available_torque <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      roc_pkg::REG_TORQUE_MODE:     prdata = {28'd0, cfg_q.torque_mode};
      roc_pkg::REG_ASSIST_ENABLES:  prdata = {28'd0, cfg_q.assist_enables};
      roc_pkg::REG_ACTUAL_TORQUE:   prdata = {24'd0, cfg_q.actual_torque};
      roc_pkg::REG_INTENDED_TORQUE: prdata = {24'd0, cfg_q.intended_torque};
      roc_pkg::REG_LOAD_LIGHT:      prdata = {28'd0, cfg_q.load_and_light_bits};
      roc_pkg::REG_DRIVER_DEMAND:   prdata = {24'd0, cfg_q.driver_demand_torque};
      roc_pkg::REG_RETARDER_SEL:    prdata = {24'd0, cfg_q.retarder_selection};
      roc_pkg::REG_MAX_AVAIL:       prdata = {24'd0, cfg_q.max_available_torque};
      default:                      prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

/* src/roc_core.sv */
`default_nettype none

module roc_core #(
  parameter int unsigned TIMEOUT_MS     = 150,
  parameter int unsigned SEND_PERIOD_MS = 100
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  roc_in_if.sink       in_i,
  output roc_pkg::job_t job_o,
  output logic         job_valid_o,
  input  wire logic    job_take_i
);

  localparam logic [31:0] Timeout = 32'(TIMEOUT_MS);
  localparam logic [31:0] Period  = 32'(SEND_PERIOD_MS);

  logic        active_q, active_d;
  logic [31:0] deadline_q, deadline_d;
  logic [7:0]  addr_q, addr_d;
  logic [31:0] last_send_q, last_send_d;

  roc_pkg::job_t pend_q, pend_d;
  logic          pend_valid_q;
  logic          accept;
  logic          send;
  logic          changed;
  logic [31:0]   since_send;
  logic [1:0]    mode;

  // result register frees when the sequencer takes it
  assign in_i.ready  = !pend_valid_q || job_take_i;
  assign accept      = in_i.valid && in_i.ready;
  assign job_o       = pend_q;
  assign job_valid_o = pend_valid_q;

  assign since_send = in_i.now_ms - last_send_q;
  assign mode       = in_i.control_byte[1:0];

  // state update for one item
  always_comb begin
    active_d    = active_q;
    deadline_d  = deadline_q;
    addr_d      = addr_q;
    last_send_d = last_send_q;
    send        = 1'b0;
    changed     = 1'b0;
    case (roc_pkg::cmd_e'(in_i.command))
      roc_pkg::CMD_OVERRIDE: begin
        if (mode == roc_pkg::MODE_STOP) begin
          if (active_q) begin
            active_d   = 1'b0;
            deadline_d = 32'd0;
            addr_d     = roc_pkg::NO_ADDRESS;
            changed    = 1'b1;
          end
        end else if (mode[1]) begin
          deadline_d = in_i.now_ms + Timeout;
          if (!active_q) begin
            active_d = 1'b1;
            addr_d   = in_i.source_address;
            changed  = 1'b1;
          end
        end
      end
      roc_pkg::CMD_TICK: begin
        send = since_send >= Period;
        if (active_q && (deadline_q <= in_i.now_ms)) begin
          active_d   = 1'b0;
          deadline_d = 32'd0;
          addr_d     = roc_pkg::NO_ADDRESS;
          changed    = 1'b1;
        end
      end
      roc_pkg::CMD_REQUEST: begin
        send = in_i.requested_pgn == roc_pkg::STATUS_PGN;
      end
      default: ;
    endcase
    if (send) begin
      last_send_d = in_i.now_ms;
    end
    // frame shows the state at the moment of sending, before any timeout stop
    pend_d.send       = send;
    pend_d.snd_active = active_q;
    pend_d.snd_addr   = addr_q;
    pend_d.changed    = changed;
    pend_d.active     = active_d;
    pend_d.addr       = addr_d;
  end

  // override state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      deadline_q  <= 32'd0;
      addr_q      <= roc_pkg::NO_ADDRESS;
      last_send_q <= 32'd0;
    end else if (accept) begin
      active_q    <= active_d;
      deadline_q  <= deadline_d;
      addr_q      <= addr_d;
      last_send_q <= last_send_d;
    end
  end

  // result register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
    end else if (accept) begin
      pend_valid_q <= 1'b1;
    end else if (job_take_i) begin
      pend_valid_q <= 1'b0;
    end
  end

  // result register payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      pend_q <= pend_d;
    end
  end

endmodule

`default_nettype wire

/* src/roc_emit.sv */
`default_nettype none

`include "retarder_override_controller_macros.svh"

module roc_emit (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire roc_pkg::cfg_t cfg_i,
  input  wire roc_pkg::job_t job_i,
  input  wire logic          job_valid_i,
  output      logic          job_take_o,
  roc_out_if.source          out_o
);

  roc_pkg::job_t cur_q;
  logic          cur_valid_q;
  logic [3:0]    cnt_q;
  logic          frame_beat;
  logic          beat_done;
  logic          item_done;
  logic [7:0]    fbyte;

  // frame beats come first when the item sends, then the status beat
  assign frame_beat = cur_q.send && !cnt_q[3];
  assign beat_done  = out_o.valid && out_o.ready;
  assign item_done  = beat_done && !frame_beat;
  assign job_take_o = job_valid_i && (!cur_valid_q || item_done);

  // frame byte select
  always_comb begin
    case (cnt_q[2:0])
      3'd0:    fbyte = {cfg_i.assist_enables, cfg_i.torque_mode};
      3'd1:    fbyte = cfg_i.actual_torque;
      3'd2:    fbyte = cfg_i.intended_torque;
      3'd3:    fbyte = {roc_pkg::BYTE3_HIGH, cfg_i.load_and_light_bits};
      3'd4:    fbyte = cur_q.snd_addr;
      3'd5:    fbyte = cfg_i.driver_demand_torque;
      3'd6:    fbyte = cfg_i.retarder_selection;
      default: fbyte = cfg_i.max_available_torque;
    endcase
  end

  // output transaction fields
  assign out_o.valid              = cur_valid_q;
  assign out_o.kind               = frame_beat ? roc_pkg::KIND_FRAME : roc_pkg::KIND_STATUS;
  assign out_o.changed            = frame_beat ? 1'b0 : cur_q.changed;
  assign out_o.active             = frame_beat ? cur_q.snd_active : cur_q.active;
  assign out_o.controller_address = frame_beat ? cur_q.snd_addr : cur_q.addr;
  assign out_o.frame_byte         = frame_beat ? fbyte : 8'd0;
  assign out_o.byte_index         = frame_beat ? cnt_q[2:0] : 3'd0;
  assign out_o.last               = !frame_beat;

  // beat sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_valid_q <= 1'b0;
      cnt_q       <= 4'd0;
    end else if (job_take_o) begin
      cur_valid_q <= 1'b1;
      cnt_q       <= 4'd0;
    end else if (item_done) begin
      cur_valid_q <= 1'b0;
      cnt_q       <= 4'd0;
    end else if (beat_done) begin
      cnt_q       <= cnt_q + 4'd1;
    end
  end

  // current item payload
  always_ff @(posedge clk_i) begin
    if (job_take_o) begin
      cur_q <= job_i;
    end
  end

  // checks
  `ROC_ASSERT_IMP(a_take_when_free, job_take_o, !cur_valid_q || item_done, "job taken while busy")
  `ROC_ASSERT_NXT(a_beat_advance, beat_done && frame_beat, cnt_q == $past(cnt_q) + 4'd1, "beat count slip")
  `ROC_ASSERT_NXT(a_idle_after_last, item_done && !job_valid_i, !out_o.valid, "result after last")
  `ROC_ASSERT_IMP(a_count_range, cur_valid_q, cnt_q <= 4'd8, "beat count out of range")

endmodule

`default_nettype wire

/* src/retarder_override_controller.sv */
// an accepted item passes the result register, then the current-item register, before it shows
// throughput: one item per ready cycle if no frame is sent; a frame item adds eight frame beats
// the sequencer sets the pace, one beat per ready cycle; a further item waits in the result register
// reset: override inactive, deadline 0, controlling address 255, last send time 0,
//   configuration registers at their documented defaults; no clearing pass
`default_nettype none

module retarder_override_controller #(
  parameter int unsigned TIMEOUT_MS     = 150,
  parameter int unsigned SEND_PERIOD_MS = 100
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  roc_in_if.sink                           in_i,
  roc_out_if.source                        out_o,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [roc_pkg::PADDR_W-1:0] paddr,
  input  wire logic [31:0]                 pwdata,
  output      logic [31:0]                 prdata,
  output      logic                        pready
);

  roc_pkg::cfg_t cfg;
  roc_pkg::job_t job;
  logic          job_valid;
  logic          job_take;

  // configuration registers
  roc_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  // override state and per-item decision
  roc_core #(
    .TIMEOUT_MS     (TIMEOUT_MS),
    .SEND_PERIOD_MS (SEND_PERIOD_MS)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .job_o       (job),
    .job_valid_o (job_valid),
    .job_take_i  (job_take)
  );

  // result sequencer
  roc_emit u_emit (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .job_i       (job),
    .job_valid_i (job_valid),
    .job_take_o  (job_take),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

/* tb/sv/tb_retarder_override_controller.sv */
module tb_retarder_override_controller;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned TIMEOUT_MS     = 150;
  localparam int unsigned SEND_PERIOD_MS = 100;
  localparam longint      CYCLE_LIMIT    = 400000;

  // override modes besides stop, and the command code the block must ignore
  localparam logic [1:0] MODE_IGNORED = 2'd1;
  localparam logic [1:0] MODE_ARM     = 2'd2;
  localparam logic [1:0] MODE_ARM_ALT = 2'd3;
  localparam logic [1:0] CMD_UNKNOWN  = 2'd3;

  typedef struct packed {
    logic       kind;
    logic       changed;
    logic       active;
    logic [7:0] addr;
    logic [7:0] fbyte;
    logic [2:0] idx;
    logic       last;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [roc_pkg::PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  roc_in_if  in_if ();
  roc_out_if out_if ();

  retarder_override_controller dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_i    (in_if),
    .out_o   (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // shadow copy of the controller state and its register settings
  roc_pkg::cfg_t settings;
  logic        override_on;
  logic [31:0] deadline_ms;
  logic [7:0]  ctl_addr;
  logic [31:0] last_sent_ms;

  beat_t       beats_due[$];

  int          errors;
  int          items_sent;
  int          beats_seen;
  int          frames_seen;
  int          settings_written;
  longint      cycles;
  logic        idle_on;
  int          stall_left;
  logic [31:0] clock_ms;

  // clock
  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // run limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: run stopped after %0d cycles, %0d results still due",
               $time, cycles, beats_due.size());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // result side backpressure in random bursts
  always @(negedge clk_i) begin
    if (!idle_on) begin
      out_if.ready = 1'b1;
    end else if (stall_left > 0) begin
      out_if.ready = 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 5) == 0) begin
      stall_left    = $urandom_range(0, 8);
      out_if.ready = 1'b0;
    end else begin
      out_if.ready = 1'b1;
    end
  end

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (got !== want) begin
      errors++;
      $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
    end
  endfunction

  // compare every result transaction with the oldest expectation
  always @(posedge clk_i) begin : result_check
    beat_t want;
    if (rst_ni && out_if.valid && out_if.ready) begin
      beats_seen++;
      if (beats_due.size() == 0) begin
        errors++;
        $display("%0t: result with nothing due, expected none, got kind %0d index %0d",
                 $time, out_if.kind, out_if.byte_index);
      end else begin
        want = beats_due.pop_front();
        check_field("kind", 32'(want.kind), 32'(out_if.kind));
        check_field("changed", 32'(want.changed), 32'(out_if.changed));
        check_field("active", 32'(want.active), 32'(out_if.active));
        check_field("controller_address", 32'(want.addr),
                    32'(out_if.controller_address));
        check_field("frame_byte", 32'(want.fbyte), 32'(out_if.frame_byte));
        check_field("byte_index", 32'(want.idx), 32'(out_if.byte_index));
        check_field("last", 32'(want.last), 32'(out_if.last));
        if (want.kind == roc_pkg::KIND_FRAME && want.idx == roc_pkg::LAST_FRAME_BYTE) begin
          frames_seen++;
        end
      end
    end
  end

  function automatic void reset_shadow();
    settings = '{torque_mode:          roc_pkg::RST_TORQUE_MODE,
                 assist_enables:       roc_pkg::RST_ASSIST_ENABLES,
                 actual_torque:        roc_pkg::RST_ACTUAL_TORQUE,
                 intended_torque:      roc_pkg::RST_INTENDED_TORQUE,
                 load_and_light_bits:  roc_pkg::RST_LOAD_LIGHT,
                 driver_demand_torque: roc_pkg::RST_DRIVER_DEMAND,
                 retarder_selection:   roc_pkg::RST_RETARDER_SEL,
                 max_available_torque: roc_pkg::RST_MAX_AVAIL};
    override_on  = 1'b0;
    deadline_ms  = '0;
    ctl_addr     = roc_pkg::NO_ADDRESS;
    last_sent_ms = '0;
  endfunction

  function automatic void end_override();
    override_on = 1'b0;
    deadline_ms = '0;
    ctl_addr    = roc_pkg::NO_ADDRESS;
  endfunction

  // eight status frame bytes as seen at the moment of sending
  function automatic void queue_status_frame(logic [31:0] now);
    logic [7:0] bytes [8];
    int i;
    bytes[0] = {settings.assist_enables, settings.torque_mode};
    bytes[1] = settings.actual_torque;
    bytes[2] = settings.intended_torque;
    bytes[3] = {roc_pkg::BYTE3_HIGH, settings.load_and_light_bits};
    bytes[4] = ctl_addr;
    bytes[5] = settings.driver_demand_torque;
    bytes[6] = settings.retarder_selection;
    bytes[7] = settings.max_available_torque;
    for (i = 0; i < 8; i++) begin
      beats_due.push_back('{roc_pkg::KIND_FRAME, 1'b0, override_on, ctl_addr, bytes[i],
                            3'(i), 1'b0});
    end
    last_sent_ms = now;
  endfunction

  // expected results of one accepted item, state updated in place
  function automatic void predict_override_item(logic [1:0] cmd, logic [31:0] now,
                                                logic [7:0] sa, logic [7:0] ctrl,
                                                logic [23:0] pgn);
    logic        chg;
    logic [1:0]  mode;
    logic [31:0] since;
    chg   = 1'b0;
    mode  = ctrl[1:0];
    since = now - last_sent_ms;
    case (cmd)
      roc_pkg::CMD_OVERRIDE: begin
        if (mode == roc_pkg::MODE_STOP) begin
          if (override_on) begin
            end_override();
            chg = 1'b1;
          end
        end else if (mode == MODE_ARM || mode == MODE_ARM_ALT) begin
          deadline_ms = now + TIMEOUT_MS;
          if (!override_on) begin
            override_on = 1'b1;
            ctl_addr    = sa;
            chg         = 1'b1;
          end
        end
      end
      roc_pkg::CMD_TICK: begin
        if (since >= SEND_PERIOD_MS) queue_status_frame(now);
        // plain unsigned compare, a wrapped deadline retires at once
        if (override_on && deadline_ms <= now) begin
          end_override();
          chg = 1'b1;
        end
      end
      roc_pkg::CMD_REQUEST: begin
        if (pgn == roc_pkg::STATUS_PGN) queue_status_frame(now);
      end
      default: begin
      end
    endcase
    beats_due.push_back('{roc_pkg::KIND_STATUS, chg, override_on, ctl_addr, 8'h00, 3'd0,
                          1'b1});
  endfunction

  function automatic roc_pkg::cfg_t random_settings();
    logic [63:0] raw;
    raw = {$urandom, $urandom};
    return raw[$bits(roc_pkg::cfg_t)-1:0];
  endfunction

  task automatic apply_reset();
    rst_ni = 1'b0;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
  endtask

  // one input transaction, with an optional random gap ahead of it
  task automatic send_item(logic [1:0] cmd, logic [31:0] now, logic [7:0] sa,
                           logic [7:0] ctrl, logic [23:0] pgn);
    int gap;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_if.valid = 1'b0;
      gap = $urandom_range(1, 9);
      repeat (gap) @(negedge clk_i);
    end
    in_if.command        = cmd;
    in_if.now_ms         = now;
    in_if.source_address = sa;
    in_if.control_byte   = ctrl;
    in_if.requested_pgn  = pgn;
    in_if.valid          = 1'b1;
    do @(posedge clk_i); while (!in_if.ready);
    predict_override_item(cmd, now, sa, ctrl, pgn);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    in_if.valid = 1'b0;
    while (beats_due.size() != 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_register(roc_pkg::reg_idx_e idx, logic [31:0] val);
    psel    = 1'b1;
    pwrite  = 1'b1;
    penable = 1'b0;
    paddr   = {idx, 2'b00};
    pwdata  = val;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    case (idx)
      roc_pkg::REG_TORQUE_MODE:     settings.torque_mode          = val[3:0];
      roc_pkg::REG_ASSIST_ENABLES:  settings.assist_enables       = val[3:0];
      roc_pkg::REG_ACTUAL_TORQUE:   settings.actual_torque        = val[7:0];
      roc_pkg::REG_INTENDED_TORQUE: settings.intended_torque      = val[7:0];
      roc_pkg::REG_LOAD_LIGHT:      settings.load_and_light_bits  = val[3:0];
      roc_pkg::REG_DRIVER_DEMAND:   settings.driver_demand_torque = val[7:0];
      roc_pkg::REG_RETARDER_SEL:    settings.retarder_selection   = val[7:0];
      roc_pkg::REG_MAX_AVAIL:       settings.max_available_torque = val[7:0];
      default: begin
      end
    endcase
    settings_written++;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // all eight registers, only once the block has gone quiet
  task automatic write_settings(roc_pkg::cfg_t c);
    roc_pkg::reg_idx_e idx;
    logic [31:0]       val;
    wait_drained();
    idx = idx.first();
    repeat (idx.num()) begin
      case (idx)
        roc_pkg::REG_TORQUE_MODE:     val = 32'(c.torque_mode);
        roc_pkg::REG_ASSIST_ENABLES:  val = 32'(c.assist_enables);
        roc_pkg::REG_ACTUAL_TORQUE:   val = 32'(c.actual_torque);
        roc_pkg::REG_INTENDED_TORQUE: val = 32'(c.intended_torque);
        roc_pkg::REG_LOAD_LIGHT:      val = 32'(c.load_and_light_bits);
        roc_pkg::REG_DRIVER_DEMAND:   val = 32'(c.driver_demand_torque);
        roc_pkg::REG_RETARDER_SEL:    val = 32'(c.retarder_selection);
        default:                      val = 32'(c.max_available_torque);
      endcase
      write_register(idx, val);
      idx = idx.next();
    end
  endtask

  // hand-picked items around each corner of the override and send logic
  task automatic test_directed_cases();
    // status frame with reset settings, then the send period boundary
    send_item(roc_pkg::CMD_REQUEST, 32'd5, 8'h00, 8'h00, roc_pkg::STATUS_PGN);
    send_item(roc_pkg::CMD_TICK, 32'd104, 8'h00, 8'h00, 24'h0);
    send_item(roc_pkg::CMD_TICK, 32'd105, 8'h00, 8'h00, 24'h0);
    // stop while inactive, ignored mode, start, re-arm from another sender
    send_item(roc_pkg::CMD_OVERRIDE, 32'd110, 8'h12, {6'h00, roc_pkg::MODE_STOP}, 24'h0);
    send_item(roc_pkg::CMD_OVERRIDE, 32'd111, 8'h34, {6'h3F, MODE_IGNORED}, 24'h0);
    send_item(roc_pkg::CMD_OVERRIDE, 32'd120, 8'h00, {6'h00, MODE_ARM}, 24'h0);
    send_item(roc_pkg::CMD_OVERRIDE, 32'd200, 8'hFF, {6'h3F, MODE_ARM_ALT}, 24'h0);
    send_item(roc_pkg::CMD_REQUEST, 32'd210, 8'h00, 8'h00, roc_pkg::STATUS_PGN);
    // one ms short of the deadline, then on it
    send_item(roc_pkg::CMD_TICK, 32'd349, 8'h00, 8'h00, 24'h0);
    send_item(roc_pkg::CMD_TICK, 32'd350, 8'h00, 8'h00, 24'h0);
    // start then stop with high control bits set
    send_item(roc_pkg::CMD_OVERRIDE, 32'd400, 8'hA5, {6'h15, MODE_ARM}, 24'h0);
    send_item(roc_pkg::CMD_OVERRIDE, 32'd401, 8'h33, {6'h3F, roc_pkg::MODE_STOP}, 24'h0);
    // deadline wraps past zero and ends at the next tick
    send_item(roc_pkg::CMD_OVERRIDE, 32'hFFFF_FFA0, 8'h5A, {6'h2A, MODE_ARM_ALT}, 24'h0);
    send_item(roc_pkg::CMD_TICK, 32'hFFFF_FFB0, 8'h00, 8'h00, 24'h0);
    // send period across the counter wrap
    send_item(roc_pkg::CMD_TICK, 32'h0000_0010, 8'h00, 8'h00, 24'h0);
    send_item(roc_pkg::CMD_TICK, 32'h0000_0014, 8'h00, 8'h00, 24'h0);
    // requests for other group numbers
    send_item(roc_pkg::CMD_REQUEST, 32'd500, 8'h00, 8'h00, 24'hFFFFFF);
    send_item(roc_pkg::CMD_REQUEST, 32'd501, 8'h00, 8'h00, 24'h000000);
    send_item(roc_pkg::CMD_REQUEST, 32'd502, 8'h00, 8'h00, roc_pkg::STATUS_PGN + 24'd1);
    send_item(roc_pkg::CMD_REQUEST, 32'd503, 8'h00, 8'h00,
              roc_pkg::STATUS_PGN | 24'hFF0000);
    // unknown command leaves everything alone
    send_item(CMD_UNKNOWN, 32'hFFFF_FFFF, 8'hFF, {6'h00, MODE_ARM}, roc_pkg::STATUS_PGN);
    send_item(roc_pkg::CMD_TICK, 32'hFFFF_FFFF, 8'h00, 8'h00, 24'h0);
    // override still running after a send
    send_item(roc_pkg::CMD_OVERRIDE, 32'h8000_0000, 8'h80, {6'h00, MODE_ARM}, 24'h0);
    send_item(roc_pkg::CMD_TICK, 32'h8000_0095, 8'h00, 8'h00, 24'h0);
    send_item(roc_pkg::CMD_OVERRIDE, 32'h0000_0000, 8'h80, {6'h00, roc_pkg::MODE_STOP},
              24'h0);
  endtask

  // frame contents under all-zero, all-one and random register settings
  task automatic test_register_settings();
    clock_ms = 32'd1000;
    write_settings('0);
    send_item(roc_pkg::CMD_OVERRIDE, clock_ms, 8'h01, {6'h00, MODE_ARM}, 24'h0);
    send_item(roc_pkg::CMD_REQUEST, clock_ms + 1, 8'h00, 8'h00, roc_pkg::STATUS_PGN);
    send_item(roc_pkg::CMD_TICK, clock_ms + 120, 8'h00, 8'h00, 24'h0);
    write_settings('1);
    send_item(roc_pkg::CMD_REQUEST, clock_ms + 130, 8'h00, 8'h00, roc_pkg::STATUS_PGN);
    send_item(roc_pkg::CMD_TICK, clock_ms + 260, 8'h00, 8'h00, 24'h0);
    send_item(roc_pkg::CMD_OVERRIDE, clock_ms + 270, 8'hFE, {6'h00, MODE_ARM_ALT}, 24'h0);
    write_settings(random_settings());
    send_item(roc_pkg::CMD_REQUEST, clock_ms + 280, 8'h00, 8'h00, roc_pkg::STATUS_PGN);
    send_item(roc_pkg::CMD_OVERRIDE, clock_ms + 290, 8'h00, {6'h00, roc_pkg::MODE_STOP},
              24'h0);
    clock_ms = clock_ms + 300;
  endtask

  // mostly plausible bus traffic on a running clock, some random noise
  task automatic test_random_traffic(int count);
    int unsigned pick;
    logic [1:0]  cmd;
    logic [31:0] now;
    logic [7:0]  sa;
    logic [7:0]  ctrl;
    logic [23:0] pgn;
    repeat (count) begin
      sa   = 8'($urandom);
      ctrl = 8'($urandom);
      pgn  = 24'($urandom);
      if ($urandom_range(0, 99) < 85) begin
        clock_ms += $urandom_range(0, 60);
        if ($urandom_range(0, 49) == 0) clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
        now  = clock_ms;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
          cmd = roc_pkg::CMD_TICK;
        end else if (pick < 65) begin
          cmd       = roc_pkg::CMD_OVERRIDE;
          ctrl[1:0] = $urandom_range(0, 1) ? MODE_ARM : MODE_ARM_ALT;
        end else if (pick < 75) begin
          cmd       = roc_pkg::CMD_OVERRIDE;
          ctrl[1:0] = roc_pkg::MODE_STOP;
        end else if (pick < 80) begin
          cmd       = roc_pkg::CMD_OVERRIDE;
          ctrl[1:0] = MODE_IGNORED;
        end else if (pick < 92) begin
          cmd = roc_pkg::CMD_REQUEST;
          pgn = roc_pkg::STATUS_PGN;
        end else begin
          cmd = roc_pkg::CMD_REQUEST;
        end
      end else begin
        now = $urandom;
        cmd = 2'($urandom_range(0, 2));
        if ($urandom_range(0, 19) == 0) cmd = CMD_UNKNOWN;
      end
      send_item(cmd, now, sa, ctrl, pgn);
    end
  endtask

  initial begin
    rst_ni               = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    in_if.valid          = 1'b0;
    in_if.command        = roc_pkg::CMD_TICK;
    in_if.now_ms         = '0;
    in_if.source_address = '0;
    in_if.control_byte   = '0;
    in_if.requested_pgn  = '0;
    out_if.ready         = 1'b0;
    idle_on              = 1'b1;
    stall_left           = 0;
    errors               = 0;
    items_sent           = 0;
    beats_seen           = 0;
    frames_seen          = 0;
    settings_written     = 0;
    cycles               = 0;
    clock_ms             = '0;
    reset_shadow();

    apply_reset();
    test_directed_cases();
    test_register_settings();
    test_random_traffic(110);
    write_settings(random_settings());
    test_random_traffic(80);
    // closing stretch without any idling
    write_settings(random_settings());
    idle_on = 1'b0;
    test_random_traffic(40);
    wait_drained();

    $display("covered %0d items giving %0d results and %0d status frames",
             items_sent, beats_seen, frames_seen);
    $display("%0d register writes over settings from all zeros to all ones",
             settings_written);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+src
src/roc_pkg.sv
src/roc_in_if.sv
src/roc_out_if.sv
src/roc_regs.sv
src/roc_core.sv
src/roc_emit.sv
src/retarder_override_controller.sv
tb/sv/tb_retarder_override_controller.sv
